// ===== hw/rtl/psgc_pkg.sv =====
// Package for the per-stream sequence gap checker.
// Holds opcode and status codes, widths and the controller state type.
// No dependencies.
`timescale 1ns / 1ps

package psgc_pkg;

  localparam int ID_W          = 10;
  localparam int STREAM_COUNT  = 2 ** ID_W;
  localparam int SEQ_WIDTH_DEF = 32;
  localparam int OP_W          = 2;
  localparam int ST_W          = 2;

  localparam logic [OP_W-1:0] OP_OBSERVE    = 2'd0;
  localparam logic [OP_W-1:0] OP_FORGET_ONE = 2'd1;
  localparam logic [OP_W-1:0] OP_FORGET_ALL = 2'd2;

  localparam logic [ST_W-1:0] ST_OK  = 2'd0;
  localparam logic [ST_W-1:0] ST_GAP = 2'd1;
  localparam logic [ST_W-1:0] ST_DUP = 2'd2;

  typedef enum logic {
    MODE_SWEEP,
    MODE_RUN
  } mode_t;

endpackage

// ===== hw/rtl/psgc_if.sv =====
// Channel interfaces for the per-stream sequence gap checker.
// psgc_in_if carries command beats, psgc_out_if carries result beats.
// Depends on psgc_pkg.
`timescale 1ns / 1ps

interface psgc_in_if import psgc_pkg::*; #(
  parameter int SEQ_WIDTH = SEQ_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [ID_W-1:0]      stream_id;
  logic [SEQ_WIDTH-1:0] seq_number;

  modport source (output valid, output opcode, output stream_id, output seq_number,
                  input ready);
  modport sink   (input valid, input opcode, input stream_id, input seq_number,
                  output ready);
endinterface

interface psgc_out_if import psgc_pkg::*; #(
  parameter int SEQ_WIDTH = SEQ_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [ST_W-1:0]      check_status;
  logic [ID_W-1:0]      result_stream_id;
  logic [SEQ_WIDTH:0]   expected_number;
  logic [SEQ_WIDTH-1:0] observed_number;

  modport source (output valid, output check_status, output result_stream_id,
                  output expected_number, output observed_number, input ready);
  modport sink   (input valid, input check_status, input result_stream_id,
                  input expected_number, input observed_number, output ready);
endinterface

// ===== hw/rtl/per_stream_sequence_gap_check_core.sv =====
// Per-stream sequence gap checker: one table entry {seen, last} per stream.
// Depends on psgc_pkg and psgc_if.
//
//   channel  dir  beat contents                                       handshake
//   feed     in   opcode, stream_id, seq_number                       valid/ready
//   report   out  check_status, result_stream_id, expected_number,   valid/ready
//                 observed_number
//
// One beat per cycle while report is taken. Each beat reads its table entry; an
// observe that is no duplicate, or a forget-one, writes it back, with the previous
// write forwarded to the next read. Reset runs a clearing pass over all STREAM_COUNT
// (1024) entries with feed.ready low. Forget-all holds feed.ready low while it sits
// in the compare stage after its beat, then through the same clearing pass.
// A stalled report holds an observe beat in the compare stage and lowers feed.ready.
`timescale 1ns / 1ps

module per_stream_sequence_gap_check_core import psgc_pkg::*; #(
  parameter int SEQ_WIDTH = SEQ_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  psgc_in_if.sink    feed,
  psgc_out_if.source report
);

  localparam int EXP_W = SEQ_WIDTH + 1;

  mode_t                 mode;
  mode_t                 mode_next;
  logic [ID_W-1:0]       sweep_cnt;

  logic                  s1_valid;
  logic [OP_W-1:0]       s1_op;
  logic [ID_W-1:0]       s1_id;
  logic [SEQ_WIDTH-1:0]  s1_seq;

  logic [SEQ_WIDTH:0]    mem [STREAM_COUNT];
  logic [SEQ_WIDTH:0]    rd_data;
  logic [ID_W-1:0]       rd_addr;

  logic                  wr_en;
  logic [ID_W-1:0]       wr_addr;
  logic [SEQ_WIDTH:0]    wr_data;

  logic                  fwd_valid;
  logic [ID_W-1:0]       fwd_slot;
  logic [SEQ_WIDTH:0]    fwd_data;

  logic                  accept;
  logic                  s1_obs;
  logic                  s1_go;
  logic [SEQ_WIDTH:0]    cur;
  logic [EXP_W-1:0]      expected;
  logic [EXP_W-1:0]      obs_ext;
  logic [ST_W-1:0]       status;

  logic                  out_valid;
  logic [ST_W-1:0]       out_status;
  logic [ID_W-1:0]       out_id;
  logic [EXP_W-1:0]      out_expected;
  logic [SEQ_WIDTH-1:0]  out_observed;

  assign accept     = feed.valid && feed.ready;
  assign s1_obs     = s1_valid && (s1_op == OP_OBSERVE);
  assign s1_go      = !s1_obs || !out_valid || report.ready;
  assign feed.ready = (mode == MODE_RUN)
                      && !(s1_valid && ((s1_op == OP_FORGET_ALL) || !s1_go));
  assign rd_addr    = accept ? feed.stream_id : s1_id;

  // Compare stage
  always_comb begin
    cur      = (fwd_valid && (fwd_slot == s1_id)) ? fwd_data : rd_data;
    expected = cur[SEQ_WIDTH] ? ({1'b0, cur[SEQ_WIDTH-1:0]} + EXP_W'(1)) : EXP_W'(1);
    obs_ext  = {1'b0, s1_seq};
    priority if (obs_ext == expected) begin
      status = ST_OK;
    end else if (obs_ext > expected) begin
      status = ST_GAP;
    end else begin
      status = ST_DUP;
    end
  end

  // Table write port and controller
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = s1_id;
    wr_data   = {1'b0, s1_seq};
    mode_next = mode;
    unique case (mode)
      MODE_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_cnt;
        wr_data = '0;
        if (sweep_cnt == ID_W'(STREAM_COUNT - 1)) begin
          mode_next = MODE_RUN;
        end
      end
      MODE_RUN: begin
        if (s1_valid && s1_go) begin
          if (s1_op == OP_OBSERVE && status != ST_DUP) begin
            wr_en   = 1'b1;
            wr_data = {1'b1, s1_seq};
          end else if (s1_op == OP_FORGET_ONE) begin
            wr_en   = 1'b1;
            wr_data = {1'b0, s1_seq};
          end else if (s1_op == OP_FORGET_ALL) begin
            mode_next = MODE_SWEEP;
          end
        end
      end
      default: mode_next = MODE_SWEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_SWEEP;
      sweep_cnt <= '0;
    end else begin
      mode      <= mode_next;
      sweep_cnt <= (mode == MODE_SWEEP) ? sweep_cnt + ID_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en && (mode == MODE_RUN);
    end
    fwd_slot <= wr_addr;
    fwd_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_op  <= feed.opcode;
      s1_id  <= feed.stream_id;
      s1_seq <= feed.seq_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_obs && s1_go) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_obs && s1_go) begin
      out_status   <= status;
      out_id       <= s1_id;
      out_expected <= expected;
      out_observed <= s1_seq;
    end
  end

  assign report.valid            = out_valid;
  assign report.check_status     = out_status;
  assign report.result_stream_id = out_id;
  assign report.expected_number  = out_expected;
  assign report.observed_number  = out_observed;

endmodule

// ===== hw/rtl/psgc_checker.sv =====
// Port-level checks for the per-stream sequence gap checker.
// Bound to per_stream_sequence_gap_check_core; depends on psgc_pkg.
`timescale 1ns / 1ps

module psgc_checker import psgc_pkg::*; #(
  parameter int SEQ_WIDTH = SEQ_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [OP_W-1:0]      in_opcode,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [ST_W-1:0]      out_status,
  input logic [SEQ_WIDTH:0]   out_expected,
  input logic [SEQ_WIDTH-1:0] out_observed
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_ok_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_OK) |-> ({1'b0, out_observed} == out_expected))
    else $error("ok status with mismatched numbers");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_status == ST_GAP) && ({1'b0, out_observed} > out_expected))
               || ((out_status == ST_DUP) && ({1'b0, out_observed} < out_expected))
               || (out_status == ST_OK))
    else $error("status disagrees with number ordering");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready during clearing pass after reset");

  a_forget_all_sweep: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_opcode == OP_FORGET_ALL) |=> !in_ready)
    else $error("input ready while forget-all pending");

endmodule

bind per_stream_sequence_gap_check_core psgc_checker #(
  .SEQ_WIDTH(SEQ_WIDTH)
) u_psgc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (feed.valid),
  .in_ready     (feed.ready),
  .in_opcode    (feed.opcode),
  .out_valid    (report.valid),
  .out_ready    (report.ready),
  .out_status   (report.check_status),
  .out_expected (report.expected_number),
  .out_observed (report.observed_number)
);
